// ===== hw/rtl/csp_pkg.sv =====
// Shared types and codes for the counting semaphore with priority wait set.
package csp_pkg;

  localparam int REQ_W    = 2;
  localparam int TID_W    = 6;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 9;
  localparam int INIT_W   = 8;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_LOCK    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TRYLOCK = 2'd1;
  localparam logic [REQ_W-1:0] REQ_UNLOCK  = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_GRANTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_WAIT     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FAILED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_WOKE     = 3'd4;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TID_W-1:0]    woken_thread;
    logic [COUNT_W-1:0]  count_after;
  } result_t;

endpackage

// ===== hw/rtl/csp_if.sv =====
// Valid/ready channel interfaces for requests and results.
interface csp_req_if;
  logic                       valid;
  logic                       ready;
  logic [csp_pkg::REQ_W-1:0]  req_type;
  logic [csp_pkg::TID_W-1:0]  thread_id;

  modport source (output valid, output req_type, output thread_id, input ready);
  modport sink   (input valid, input req_type, input thread_id, output ready);
endinterface

interface csp_res_if;
  logic                          valid;
  logic                          ready;
  logic [csp_pkg::STATUS_W-1:0]  status;
  logic [csp_pkg::TID_W-1:0]     woken_thread;
  logic [csp_pkg::COUNT_W-1:0]   count_after;

  modport source (output valid, output status, output woken_thread, output count_after,
                  input ready);
  modport sink   (input valid, input status, input woken_thread, input count_after,
                  output ready);
endinterface

// ===== hw/rtl/counting_semaphore_priority_wait_top.sv =====
// Top level of the counting semaphore with a priority wait set.
// Each request beat (lock, try-lock or unlock from a thread) yields exactly one result beat.
// The block takes one request per cycle while the result channel is not stalled: a request
// accepted is captured in an input register, the count update and the priority
// encode of the wait set run combinationally against the live semaphore state, and the outcome is
// held in a result register. Back-pressure on the result channel stalls the input register and
// then the request channel. Writing cfg_initial_count reloads the count (clamped to MAX_COUNT)
// and empties the wait set; it must only be done while no request is in flight.
module counting_semaphore_priority_wait_top #(
  parameter int NUM_THREADS = 64,
  parameter int MAX_COUNT   = 255
) (
  input  logic                        clk,
  input  logic                        rst_n,
  csp_req_if.sink                     in_req,
  csp_res_if.source                   out_res,
  input  logic                        cfg_we,
  input  logic [csp_pkg::INIT_W-1:0]  cfg_initial_count
);

  localparam int POS_W  = $clog2(MAX_COUNT + 1) + 1;
  localparam int NEG_W  = $clog2(NUM_THREADS) + 1;
  localparam int CNT_W  = (POS_W > NEG_W) ? POS_W : NEG_W;
  localparam int WAIT_W = (NUM_THREADS < 64) ? NUM_THREADS : 64;
  localparam logic signed [CNT_W-1:0] CntReset = CNT_W'(1);
  localparam logic signed [CNT_W-1:0] CntMin   = CNT_W'(-NUM_THREADS);
  localparam logic signed [CNT_W-1:0] CntMax   = CNT_W'(MAX_COUNT);

  logic                          s1_valid_r;
  logic [csp_pkg::REQ_W-1:0]     s1_req_r;
  logic [csp_pkg::TID_W-1:0]     s1_tid_r;
  logic                          out_valid_r;
  csp_pkg::result_t              out_res_r;
  logic signed [CNT_W-1:0]       count_r;
  logic [WAIT_W-1:0]             bitmap_r;

  logic signed [CNT_W-1:0]       count_nxt;
  logic [WAIT_W-1:0]             bitmap_nxt;
  csp_pkg::result_t              result;
  logic signed [CNT_W-1:0]       init_count;
  logic                          s1_go;
  logic                          in_take;

  assign s1_go        = s1_valid_r && (!out_valid_r || out_res.ready);
  assign in_req.ready = !s1_valid_r || s1_go;
  assign in_take      = in_req.valid && in_req.ready;

  assign init_count = (32'(cfg_initial_count) > MAX_COUNT) ? CntMax
                                                           : CNT_W'(cfg_initial_count);

  csp_core #(
    .NUM_THREADS (NUM_THREADS),
    .MAX_COUNT   (MAX_COUNT),
    .CNT_W       (CNT_W),
    .WAIT_W      (WAIT_W)
  ) u_core (
    .req_type   (s1_req_r),
    .thread_id  (s1_tid_r),
    .count      (count_r),
    .bitmap     (bitmap_r),
    .count_nxt  (count_nxt),
    .bitmap_nxt (bitmap_nxt),
    .result     (result)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_req.ready) begin
      s1_valid_r <= in_req.valid;
    end
    if (in_take) begin
      s1_req_r <= in_req.req_type;
      s1_tid_r <= in_req.thread_id;
    end
  end

  // Semaphore state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= CntReset;
      bitmap_r <= '0;
    end else if (cfg_we) begin
      count_r  <= init_count;
      bitmap_r <= '0;
    end else if (s1_go) begin
      count_r  <= count_nxt;
      bitmap_r <= bitmap_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_res.ready) begin
      out_valid_r <= s1_valid_r;
    end
    if (s1_go) begin
      out_res_r <= result;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.status       = out_res_r.status;
  assign out_res.woken_thread = out_res_r.woken_thread;
  assign out_res.count_after  = out_res_r.count_after;

  // The count stays inside its saturation limits.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CntMin) && (count_r <= CntMax))
    else $error("semaphore count outside its range");

  // Nobody waits while the count is not negative.
  a_no_waiter: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= 0) |-> (bitmap_r == '0))
    else $error("wait set not empty with a non-negative count");

  // A beat leaving the input register always lands in the result register.
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |=> out_valid_r)
    else $error("request lost between input and result registers");

  // A woken thread was waiting in the cycle its unlock was handled.
  a_woken_waited: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && (result.status == csp_pkg::ST_WOKE)) |-> (count_r < 0) && (|bitmap_r))
    else $error("waiter woken from an empty wait set");

endmodule

// ===== hw/rtl/csp_prio_enc.sv =====
// Priority encoder: index of the lowest set bit of the wait set.
module csp_prio_enc #(
  parameter int WIDTH = 64
) (
  input  logic [WIDTH-1:0]          bits,
  output logic [csp_pkg::TID_W-1:0] idx
);

  always_comb begin
    idx = '0;
    // Scan downwards so that the lowest set bit is the last to be written.
    for (int i = WIDTH - 1; i >= 0; i--) begin
      if (bits[i]) begin
        idx = csp_pkg::TID_W'(i);
      end
    end
  end

endmodule

// ===== hw/rtl/csp_core.sv =====
// Next-state and result logic for one request against the semaphore state.
module csp_core #(
  parameter int NUM_THREADS = 64,
  parameter int MAX_COUNT   = 255,
  parameter int CNT_W       = 10,
  parameter int WAIT_W      = 64
) (
  input  logic [csp_pkg::REQ_W-1:0] req_type,
  input  logic [csp_pkg::TID_W-1:0] thread_id,
  input  logic signed [CNT_W-1:0]   count,
  input  logic [WAIT_W-1:0]         bitmap,
  output logic signed [CNT_W-1:0]   count_nxt,
  output logic [WAIT_W-1:0]         bitmap_nxt,
  output csp_pkg::result_t          result
);

  localparam logic signed [CNT_W-1:0] CntMin = CNT_W'(-NUM_THREADS);
  localparam logic signed [CNT_W-1:0] CntMax = CNT_W'(MAX_COUNT);
  localparam logic signed [CNT_W-1:0] CntOne = CNT_W'(1);
  localparam int EXT_W = (CNT_W > csp_pkg::COUNT_W) ? CNT_W : csp_pkg::COUNT_W;

  logic [csp_pkg::TID_W-1:0] woken;
  logic [WAIT_W-1:0]         set_mask;
  logic [WAIT_W-1:0]         clr_mask;
  logic signed [CNT_W-1:0]   count_dec;
  logic signed [CNT_W-1:0]   count_inc;
  logic signed [EXT_W-1:0]   count_ext;
  logic                      tid_ok;

  csp_prio_enc #(.WIDTH(WAIT_W)) u_prio_enc (
    .bits (bitmap),
    .idx  (woken)
  );

  always_comb begin
    for (int i = 0; i < WAIT_W; i++) begin
      set_mask[i] = (thread_id == csp_pkg::TID_W'(i));
      clr_mask[i] = (woken == csp_pkg::TID_W'(i));
    end
  end

  assign tid_ok    = (32'(thread_id) < NUM_THREADS);
  assign count_dec = (count == CntMin) ? count : count - CntOne;
  assign count_inc = (count == CntMax) ? count : count + CntOne;

  always_comb begin
    count_nxt           = count;
    bitmap_nxt          = bitmap;
    result.status       = csp_pkg::ST_FAILED;
    result.woken_thread = '0;
    case (req_type)
      csp_pkg::REQ_LOCK: begin
        if (tid_ok) begin
          count_nxt = count_dec;
          if (count_dec < 0) begin
            bitmap_nxt    = bitmap | set_mask;
            result.status = csp_pkg::ST_WAIT;
          end else begin
            result.status = csp_pkg::ST_GRANTED;
          end
        end
      end
      csp_pkg::REQ_TRYLOCK: begin
        if (count > 0) begin
          count_nxt     = count - CntOne;
          result.status = csp_pkg::ST_GRANTED;
        end
      end
      csp_pkg::REQ_UNLOCK: begin
        count_nxt     = count_inc;
        result.status = csp_pkg::ST_RELEASED;
        if ((count < 0) && (|bitmap)) begin
          bitmap_nxt          = bitmap & ~clr_mask;
          result.status       = csp_pkg::ST_WOKE;
          result.woken_thread = woken;
        end
      end
      default: begin
      end
    endcase
    // The result carries the low bits of the two's complement count.
    count_ext          = EXT_W'(count_nxt);
    result.count_after = count_ext[csp_pkg::COUNT_W-1:0];
  end

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the counting semaphore with priority wait set.
`timescale 1ns / 1ps

module testbench;

  localparam int NUM_THREADS = 64;
  localparam int MAX_COUNT   = 255;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 150;

  localparam logic [csp_pkg::REQ_W-1:0] REQ_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [csp_pkg::REQ_W-1:0] req_type;
    logic [csp_pkg::TID_W-1:0] thread_id;
  } request_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [csp_pkg::INIT_W-1:0] cfg_initial_count;

  csp_req_if req_bus ();
  csp_res_if res_bus ();

  counting_semaphore_priority_wait_top #(
    .NUM_THREADS(NUM_THREADS),
    .MAX_COUNT  (MAX_COUNT)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_req           (req_bus),
    .out_res          (res_bus),
    .cfg_we           (cfg_we),
    .cfg_initial_count(cfg_initial_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  request_t          pending_requests[$];
  csp_pkg::result_t  expected_results[$];
  int                failures = 0;
  int                results_seen = 0;

  // Shadow of the semaphore state.
  int          sem_count;
  logic [63:0] wait_set;

  function automatic int clamp_count(input int v);
    if (v > MAX_COUNT) return MAX_COUNT;
    if (v < -NUM_THREADS) return -NUM_THREADS;
    return v;
  endfunction

  function automatic csp_pkg::result_t semaphore_response(
      input logic [csp_pkg::REQ_W-1:0] req,
      input logic [csp_pkg::TID_W-1:0] tid);
    csp_pkg::result_t r;
    int               idx;
    r.status = csp_pkg::ST_FAILED;
    r.woken_thread = '0;
    idx = 0;
    case (req)
      csp_pkg::REQ_LOCK: begin
        if (int'(tid) < NUM_THREADS) begin
          sem_count = clamp_count(sem_count - 1);
          if (sem_count < 0) begin
            wait_set[tid] = 1'b1;
            r.status = csp_pkg::ST_WAIT;
          end else begin
            r.status = csp_pkg::ST_GRANTED;
          end
        end
      end
      csp_pkg::REQ_TRYLOCK: begin
        if (sem_count > 0) begin
          sem_count = clamp_count(sem_count - 1);
          r.status = csp_pkg::ST_GRANTED;
        end
      end
      csp_pkg::REQ_UNLOCK: begin
        r.status = csp_pkg::ST_RELEASED;
        if (sem_count < 0 && wait_set != '0) begin
          // Lowest id wins: scan downwards so the last hit is the lowest bit.
          for (int i = 63; i >= 0; i--) begin
            if (wait_set[i]) idx = i;
          end
          wait_set[idx] = 1'b0;
          r.woken_thread = idx[csp_pkg::TID_W-1:0];
          r.status = csp_pkg::ST_WOKE;
        end
        sem_count = clamp_count(sem_count + 1);
      end
      default: ;
    endcase
    r.count_after = sem_count[csp_pkg::COUNT_W-1:0];
    return r;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    request_t item;
    if (!rst_n) begin
      req_bus.valid <= 1'b0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        expected_results.push_back(semaphore_response(req_bus.req_type, req_bus.thread_id));
      end
      if (req_bus.valid && !req_bus.ready) begin
        // Beat still on offer; hold it.
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        req_bus.valid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        item = pending_requests.pop_front();
        req_bus.valid <= 1'b1;
        req_bus.req_type <= item.req_type;
        req_bus.thread_id <= item.thread_id;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 48);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern follows the cycle count, with occasional hold-offs.
  int rx_cycle = 0;
  int hold_left = 0;
  bit long_hold_done = 1'b0;

  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (!rst_n) begin
      res_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_bus.ready <= 1'b0;
    end else if (results_seen == 200 && !long_hold_done) begin
      // One long hold-off so that the block fills and stalls its input.
      long_hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      res_bus.ready <= 1'b0;
    end else if ($urandom_range(0, 499) == 0) begin
      hold_left <= $urandom_range(20, 60);
      res_bus.ready <= 1'b0;
    end else begin
      case (rx_cycle[7:6])
        2'd0: res_bus.ready <= 1'b1;
        2'd1: res_bus.ready <= ($urandom_range(0, 3) != 0);
        2'd2: res_bus.ready <= ($urandom_range(0, 1) != 0);
        default: res_bus.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Result checker.
  always @(posedge clk) begin
    csp_pkg::result_t want;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        $error("result beat with no request outstanding");
        failures++;
      end else begin
        want = expected_results.pop_front();
        if (res_bus.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, res_bus.status);
          failures++;
        end
        if (res_bus.woken_thread !== want.woken_thread) begin
          $error("woken_thread: expected %0d, actual %0d",
                 want.woken_thread, res_bus.woken_thread);
          failures++;
        end
        if (res_bus.count_after !== want.count_after) begin
          $error("count_after: expected %0d, actual %0d",
                 $signed(want.count_after), $signed(res_bus.count_after));
          failures++;
        end
      end
    end
  end

  int cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic queue_request(input logic [csp_pkg::REQ_W-1:0] req, input int tid);
    request_t item;
    item.req_type = req;
    item.thread_id = tid[csp_pkg::TID_W-1:0];
    pending_requests.push_back(item);
  endtask

  task automatic wait_for_idle();
    while (pending_requests.size() != 0 || req_bus.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Reload the count while nothing is in flight; the shadow state follows.
  task automatic set_initial_count(input int value);
    wait_for_idle();
    cfg_initial_count <= value[csp_pkg::INIT_W-1:0];
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    sem_count = clamp_count(value);
    wait_set = '0;
    @(posedge clk);
  endtask

  task automatic random_phase(input int init, input int n, input int w_lock,
                              input int w_try, input int w_unlock, input int tid_span);
    int pick;
    set_initial_count(init);
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, w_lock + w_try + w_unlock + 2);
      if (pick < w_lock)
        queue_request(csp_pkg::REQ_LOCK, $urandom_range(0, tid_span));
      else if (pick < w_lock + w_try)
        queue_request(csp_pkg::REQ_TRYLOCK, $urandom_range(0, tid_span));
      else if (pick < w_lock + w_try + w_unlock)
        queue_request(csp_pkg::REQ_UNLOCK, $urandom_range(0, tid_span));
      else
        queue_request(REQ_UNKNOWN, $urandom_range(0, 63));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_initial_count = '0;
    req_bus.valid = 1'b0;
    req_bus.req_type = csp_pkg::REQ_LOCK;
    req_bus.thread_id = '0;
    res_bus.ready = 1'b0;
    sem_count = 1;
    wait_set = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Count as left by reset: grants, waits, wake-ups in priority order,
    // an unlock with the wait set already empty, and an unknown request.
    queue_request(csp_pkg::REQ_TRYLOCK, 0);
    queue_request(csp_pkg::REQ_TRYLOCK, 1);
    queue_request(csp_pkg::REQ_LOCK, 63);
    queue_request(csp_pkg::REQ_LOCK, 0);
    queue_request(csp_pkg::REQ_LOCK, 63);
    queue_request(csp_pkg::REQ_UNLOCK, 17);
    queue_request(csp_pkg::REQ_UNLOCK, 5);
    queue_request(csp_pkg::REQ_UNLOCK, 63);
    queue_request(csp_pkg::REQ_UNLOCK, 0);
    queue_request(REQ_UNKNOWN, 63);
    queue_request(csp_pkg::REQ_LOCK, 42);

    // Full count: an unlock at the ceiling leaves the count there.
    set_initial_count(MAX_COUNT);
    queue_request(csp_pkg::REQ_UNLOCK, 21);
    queue_request(csp_pkg::REQ_UNLOCK, 42);
    queue_request(csp_pkg::REQ_TRYLOCK, 63);
    queue_request(csp_pkg::REQ_LOCK, 21);
    queue_request(REQ_UNKNOWN, 0);

    // Empty count: try-lock fails, lock waits.
    set_initial_count(0);
    queue_request(csp_pkg::REQ_TRYLOCK, 7);
    queue_request(csp_pkg::REQ_LOCK, 32);
    queue_request(csp_pkg::REQ_TRYLOCK, 31);
    queue_request(csp_pkg::REQ_UNLOCK, 0);
    queue_request(csp_pkg::REQ_UNLOCK, 0);
    queue_request(csp_pkg::REQ_LOCK, 0);

    // Lock-heavy from zero drives the count down to its floor.
    random_phase(0, 120, 80, 5, 15, 63);
    random_phase(MAX_COUNT, 90, 10, 10, 80, 63);
    random_phase($urandom_range(0, 255), 100, 35, 30, 35, 7);
    random_phase(0, 100, 45, 10, 45, 63);
    random_phase(1, 100, 40, 20, 40, 15);
    random_phase($urandom_range(0, 7), 120, 50, 15, 35, 63);
    random_phase(MAX_COUNT, 80, 60, 30, 10, 63);
    random_phase($urandom_range(0, 255), 60, 34, 33, 33, 63);
    random_phase(0, 80, 40, 20, 40, 3);

    wait_for_idle();
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
